// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bdq_pkg.sv =====
package bdq_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int KIND_W = 3;
    localparam int OCC_W  = 7;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_DUMP       = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    localparam logic [KIND_W-1:0] KIND_DONE       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY_POP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ITEM       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY_LIST = 3'd4;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic              push_front;
        logic              push_back;
        logic              rotate;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } bdq_ctl_t;

endpackage

// ===== rtl/core/bdq_cell.sv =====
module bdq_cell (
    input  logic                          clk,
    input  bdq_pkg::bdq_ctl_t             ctl,
    input  logic [bdq_pkg::IDX_W-1:0]     idx,
    input  logic [bdq_pkg::DATA_W-1:0]    left_data,
    input  logic [bdq_pkg::DATA_W-1:0]    right_data,
    input  logic [bdq_pkg::DATA_W-1:0]    front_data,
    output logic [bdq_pkg::DATA_W-1:0]    data
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  pos_plus;

    assign pos      = CNT_W'(idx);
    assign pos_plus = pos + CNT_W'(1);

    // Push front shifts toward the back; rotate shifts toward the front and
    // wraps the old front into the tail slot.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.push_front)
        begin
            data_next = left_data;
        end
        else if (ctl.push_back && (pos == ctl.count))
        begin
            data_next = ctl.value;
        end
        else if (ctl.rotate)
        begin
            if (pos_plus == ctl.count)
            begin
                data_next = front_data;
            end
            else if (pos_plus < ctl.count)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/bdq_chain.sv =====
module bdq_chain (
    input  logic                          clk,
    input  bdq_pkg::bdq_ctl_t             ctl,
    output logic [bdq_pkg::DATA_W-1:0]    front_data
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] cell_data [DEPTH];

    assign front_data = cell_data[0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = ctl.value;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        bdq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .idx        (IDX_W'(i)),
            .left_data  (left_in),
            .right_data (right_in),
            .front_data (cell_data[0]),
            .data       (cell_data[i])
        );
    end

endmodule

// ===== rtl/core/bounded_deque_push_pop_dump.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------
// request  | in_valid / in_stall   | opcode, value
// result   | out_valid / out_stall | kind, element, last, occupancy
//
// Push, pop, clear and unused opcodes give one result each.
// A dump enters the dump state and then gives one result per stored element: the
// chain rotates once per listed element and the front cell feeds the output,
// so a dump holds the request side until its last element is listed.
// rst_n clears count, dump state and output valid; cell contents hold.
// A result waits in the output register while out_stall is high; a new
// request is taken only when that register is free or being drained.
module bounded_deque_push_pop_dump (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bdq_pkg::OP_W-1:0]             opcode,
    input  logic signed [bdq_pkg::DATA_W-1:0]    value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bdq_pkg::KIND_W-1:0]           kind,
    output logic signed [bdq_pkg::DATA_W-1:0]    element,
    output logic                                 last,
    output logic [bdq_pkg::OCC_W-1:0]            occupancy
);
    import bdq_pkg::*;

    `include "assert_macros.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic              state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  remain_reg,    remain_next;
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg,      kind_next;
    logic [DATA_W-1:0] element_reg,   element_next;
    logic              last_reg,      last_next;
    logic [OCC_W-1:0]  occ_reg,       occ_next;

    bdq_ctl_t          ctl;
    logic [DATA_W-1:0] front_data;
    logic              out_free;
    logic              accept;
    logic              load;
    logic              full;
    logic              empty;
    logic              dump_step;
    logic              dump_last;
    logic              remain_ok;

    bdq_chain u_chain (
        .clk        (clk),
        .ctl        (ctl),
        .front_data (front_data)
    );

    // Output register is free when empty or being taken this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign dump_step = (state_reg == ST_DUMP) && out_free;
    assign dump_last = (remain_reg == CNT_W'(1));
    assign remain_ok = (remain_reg != '0) && (remain_reg <= count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        kind_next      = kind_reg;
        element_next   = element_reg;
        last_next      = last_reg;
        occ_next       = occ_reg;
        load           = 1'b0;

        ctl.push_front = 1'b0;
        ctl.push_back  = 1'b0;
        ctl.rotate     = 1'b0;
        ctl.value      = value;
        ctl.count      = count_reg;

        if (accept)
        begin
            load         = 1'b1;
            kind_next    = KIND_DONE;
            element_next = '0;
            last_next    = 1'b1;
            case (opcode)
                OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        kind_next = KIND_FULL;
                    end
                    else
                    begin
                        ctl.push_back = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        kind_next = KIND_FULL;
                    end
                    else
                    begin
                        ctl.push_front = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT:
                begin
                    // Rotate drops the front; the wrapped copy falls past the tail.
                    if (empty)
                    begin
                        kind_next = KIND_EMPTY_POP;
                    end
                    else
                    begin
                        ctl.rotate = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_DUMP:
                begin
                    if (empty)
                    begin
                        kind_next = KIND_EMPTY_LIST;
                    end
                    else
                    begin
                        // Results come from the dump state, one per cycle unless out_stall holds the output.
                        load        = 1'b0;
                        state_next  = ST_DUMP;
                        remain_next = count_reg;
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    kind_next = KIND_DONE;
                end
            endcase
            occ_next = OCC_W'(count_next);
        end
        else if (dump_step)
        begin
            // Emit the front and rotate it to the tail; after count steps the
            // order is back where it started.
            load         = 1'b1;
            ctl.rotate   = 1'b1;
            kind_next    = KIND_ITEM;
            element_next = front_data;
            last_next    = dump_last;
            occ_next     = OCC_W'(count_reg);
            remain_next  = remain_reg - CNT_W'(1);
            if (dump_last)
            begin
                state_next = ST_IDLE;
            end
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        element_reg <= element_next;
        last_reg    <= last_next;
        occ_reg     <= occ_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign element   = element_reg;
    assign last      = last_reg;
    assign occupancy = occ_reg;

    `BDQ_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "count beyond depth")
    `BDQ_ASSERT(a_dump_remain, (state_reg != ST_DUMP) || remain_ok, "dump remainder bad")
    `BDQ_ASSERT_NEXT(a_dump_count, state_reg == ST_DUMP, $stable(count_reg), "count moved")
    `BDQ_ASSERT_NEXT(a_dump_exit, dump_step && dump_last, state_reg == ST_IDLE, "dump overran")

endmodule

// ===== test/tb_bounded_deque_push_pop_dump.sv =====
`timescale 1ns / 100ps

module tb_bounded_deque_push_pop_dump;

    import bdq_pkg::*;

    // Opcodes the block leaves unused: each answers with a plain done result.
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int NUM_ROWS      = 25;
    localparam int RANDOM_ITEMS  = 100;
    localparam int NUM_PHASES    = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_ITEMS    = 8;
    localparam int DRAIN_CYCLES  = 20;

    // One result as the block reports it.
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] element;
        logic                     last;
        logic [OCC_W-1:0]         occupancy;
    } result_t;

    // One row of the directed table. Rows with reps above one send fresh
    // random values on every repeat; typed rows carry their answer inline.
    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        int                       reps;
        bit                       typed;
        logic [KIND_W-1:0]        t_kind;
        logic [OCC_W-1:0]         t_occ;
    } stim_row_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          opcode    = '0;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] element;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;

    // Shadow copy of the deque: ring store, front index and fill level.
    logic signed [DATA_W-1:0] deque_slots [DEPTH];
    logic [IDX_W-1:0]         deque_head = '0;
    logic [CNT_W-1:0]         deque_fill = '0;

    // Results still owed by the block, oldest first.
    result_t                  owed_results [$];

    stim_row_t                directed_rows [NUM_ROWS];

    int                       fail_count     = 0;
    int                       send_idle_pct  = 0;
    int                       recv_stall_pct = 0;
    int                       hold_token     = 0;
    int                       hold_seen      = 0;
    int                       hold_left      = 0;

    int send_idle_by_phase  [NUM_PHASES] = '{0, 48, 0, 27};
    int recv_stall_by_phase [NUM_PHASES] = '{0, 0, 48, 27};

    bounded_deque_push_pop_dump i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .element   (element),
        .last      (last),
        .occupancy (occupancy)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // Queue one single-result answer carrying the current fill level.
    function automatic void owe_single(input logic [KIND_W-1:0] k);
        owed_results.push_back('{k, '0, 1'b1, OCC_W'(deque_fill)});
    endfunction

    // Advance the shadow deque by one request and queue what it must answer.
    function automatic void track_request(input logic [OP_W-1:0] op,
                                          input logic signed [DATA_W-1:0] val);
        int i;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (deque_fill >= DEPTH)
                begin
                    // Full deque: drop the value, keep the state.
                    owe_single(KIND_FULL);
                end
                else
                begin
                    if (op == OP_PUSH_BACK)
                    begin
                        deque_slots[(deque_head + deque_fill) % DEPTH] = val;
                    end
                    else
                    begin
                        deque_head = IDX_W'((deque_head + DEPTH - 1) % DEPTH);
                        deque_slots[deque_head] = val;
                    end
                    deque_fill = deque_fill + 1'b1;
                    owe_single(KIND_DONE);
                end
            end
            OP_POP_FRONT:
            begin
                if (deque_fill == 0)
                begin
                    owe_single(KIND_EMPTY_POP);
                end
                else
                begin
                    deque_head = IDX_W'((deque_head + 1) % DEPTH);
                    deque_fill = deque_fill - 1'b1;
                    owe_single(KIND_DONE);
                end
            end
            OP_DUMP:
            begin
                if (deque_fill == 0)
                begin
                    owe_single(KIND_EMPTY_LIST);
                end
                else
                begin
                    // List front to back, flag the final element.
                    for (i = 0; i < deque_fill; i++)
                    begin
                        owed_results.push_back('{KIND_ITEM,
                                                 deque_slots[(deque_head + i) % DEPTH],
                                                 1'(i == deque_fill - 1),
                                                 OCC_W'(deque_fill)});
                    end
                end
            end
            OP_CLEAR:
            begin
                deque_fill = '0;
                deque_head = '0;
                owe_single(KIND_DONE);
            end
            default:
            begin
                owe_single(KIND_DONE);
            end
        endcase
    endfunction

    // Favor the extremes now and then, otherwise any 32-bit value.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_push();
        return ($urandom_range(1) == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    // Offer one request, hold it until the block takes it, then predict.
    // Valid stays high across back-to-back requests; drop it only for gaps.
    task automatic offer_request(input logic [OP_W-1:0] op,
                                 input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        track_request(op, val);
    endtask

    // Hold the request side idle until every owed result has come back.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (owed_results.size() != 0);
    endtask

    // Result side: check each accepted result against the oldest owed one,
    // then choose the stall for the next edge. A hold-off request from the
    // stimulus process pins the stall high while a countdown from HOLD_CYCLES runs out.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d element %0d last %0d occupancy %0d",
                         $time, kind, element, last, occupancy);
                fail_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (kind !== want.kind)
                begin
                    $display("%0t: kind expected %0d, got %0d", $time, want.kind, kind);
                    fail_count++;
                end
                if (element !== want.element)
                begin
                    $display("%0t: element expected %0d, got %0d",
                             $time, want.element, element);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0d, got %0d", $time, want.last, last);
                    fail_count++;
                end
                if (occupancy !== want.occupancy)
                begin
                    $display("%0t: occupancy expected %0d, got %0d",
                             $time, want.occupancy, occupancy);
                    fail_count++;
                end
            end
        end
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        int r;
        int k;
        int phase;
        int sent;
        int n;
        int pick;
        int room;

        // Directed table: empty-deque answers, extremes, spare opcodes,
        // fill to the brim and push past it, drain and pop past empty,
        // then wrap the front index below zero.
        directed_rows = '{
            '{OP_DUMP,       32'sd0,          1,     1'b1, KIND_EMPTY_LIST, 7'd0},
            '{OP_POP_FRONT,  32'sd0,          1,     1'b1, KIND_EMPTY_POP,  7'd0},
            '{OP_CLEAR,      32'sd0,          1,     1'b1, KIND_DONE,       7'd0},
            '{OP_PUSH_BACK,  32'sh7FFF_FFFF,  1,     1'b1, KIND_DONE,       7'd1},
            '{OP_PUSH_FRONT, 32'sh8000_0000,  1,     1'b1, KIND_DONE,       7'd2},
            '{OP_PUSH_BACK,  32'sd0,          1,     1'b1, KIND_DONE,       7'd3},
            '{OP_PUSH_FRONT, -32'sd1,         1,     1'b1, KIND_DONE,       7'd4},
            '{OP_DUMP,       32'sd0,          1,     1'b0, KIND_DONE,       7'd0},
            '{OP_SPARE_5,    -32'sd1,         1,     1'b1, KIND_DONE,       7'd4},
            '{OP_SPARE_6,    32'sd0,          1,     1'b1, KIND_DONE,       7'd4},
            '{OP_SPARE_7,    32'sh7FFF_FFFF,  1,     1'b1, KIND_DONE,       7'd4},
            '{OP_POP_FRONT,  32'sd0,          1,     1'b1, KIND_DONE,       7'd3},
            '{OP_DUMP,       32'sd0,          1,     1'b0, KIND_DONE,       7'd0},
            '{OP_CLEAR,      32'sd0,          1,     1'b1, KIND_DONE,       7'd0},
            '{OP_DUMP,       32'sd0,          1,     1'b1, KIND_EMPTY_LIST, 7'd0},
            '{OP_PUSH_FRONT, 32'sd0,          DEPTH, 1'b0, KIND_DONE,       7'd0},
            '{OP_PUSH_BACK,  32'shAAAA_AAAA,  1,     1'b1, KIND_FULL,       OCC_W'(DEPTH)},
            '{OP_PUSH_FRONT, 32'sh5555_5555,  1,     1'b1, KIND_FULL,       OCC_W'(DEPTH)},
            '{OP_DUMP,       32'sd0,          1,     1'b0, KIND_DONE,       7'd0},
            '{OP_POP_FRONT,  32'sd0,          DEPTH, 1'b0, KIND_DONE,       7'd0},
            '{OP_POP_FRONT,  32'sd0,          1,     1'b1, KIND_EMPTY_POP,  7'd0},
            '{OP_PUSH_FRONT, 32'sd0,          3,     1'b0, KIND_DONE,       7'd0},
            '{OP_PUSH_BACK,  32'sd0,          2,     1'b0, KIND_DONE,       7'd0},
            '{OP_DUMP,       32'sd0,          1,     1'b0, KIND_DONE,       7'd0},
            '{OP_CLEAR,      32'sd0,          1,     1'b1, KIND_DONE,       7'd0}
        };

        // Hold reset low, then release it on a rising edge.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table with both sides running flat out.
        for (r = 0; r < NUM_ROWS; r++)
        begin
            for (k = 0; k < directed_rows[r].reps; k++)
            begin
                if (directed_rows[r].reps > 1)
                begin
                    offer_request(directed_rows[r].op, pick_value());
                end
                else
                begin
                    offer_request(directed_rows[r].op, directed_rows[r].val);
                end
                // Swap the predicted answer for the one typed in the row.
                if (directed_rows[r].typed)
                begin
                    void'(owed_results.pop_back());
                    owed_results.push_back('{directed_rows[r].t_kind, '0, 1'b1,
                                             directed_rows[r].t_occ});
                end
            end
        end
        pause_until_drained();

        // Random part, one idling profile per phase. Most traffic comes in
        // bursts: fills capped at what the phase has left to send, drains that often run
        // past empty, and dumps between them, with stray opcodes as noise.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct  = send_idle_by_phase[phase];
            recv_stall_pct = recv_stall_by_phase[phase];

            if (phase == 2)
            begin
                // Freeze the result side while requests keep coming, so the
                // output backs up and the block stalls its request side.
                hold_token++;
                for (k = 0; k < HOLD_ITEMS; k++)
                begin
                    offer_request(pick_push(), pick_value());
                end
                pause_until_drained();
            end

            sent = 0;
            while (sent < RANDOM_ITEMS / NUM_PHASES)
            begin
                room = RANDOM_ITEMS / NUM_PHASES - sent;
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    n = ($urandom_range(3) == 0) ? $urandom_range(DEPTH - 8, DEPTH + 6)
                                                 : $urandom_range(1, 12);
                    n = (n > room) ? room : n;
                    for (k = 0; k < n; k++)
                    begin
                        offer_request(pick_push(), pick_value());
                    end
                end
                else if (pick < 60)
                begin
                    n = $urandom_range(1, DEPTH / 2 + 4);
                    n = (n > room) ? room : n;
                    for (k = 0; k < n; k++)
                    begin
                        offer_request(OP_POP_FRONT, pick_value());
                    end
                end
                else if (pick < 75)
                begin
                    n = 1;
                    offer_request(OP_DUMP, pick_value());
                end
                else if (pick < 82)
                begin
                    n = 1;
                    offer_request(OP_CLEAR, pick_value());
                end
                else
                begin
                    n = 1;
                    offer_request(OP_W'($urandom_range(7)), pick_value());
                end
                sent += n;
            end

            // Pause the request side until every owed result is in.
            pause_until_drained();
        end

        // Let any stray result surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== bounded_deque_push_pop_dump.f =====
+incdir+rtl/core
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bdq_chain.sv
rtl/core/bounded_deque_push_pop_dump.sv
test/tb_bounded_deque_push_pop_dump.sv
